[src/sce_pkg.sv]
// stereo chorus ensemble: shared constants, register codes and lookup tables
`default_nettype none
package sce_pkg;

    localparam int DELAY_DEPTH = 4096;
    localparam int ADDR_BITS   = 12;
    localparam int SAMPLE_BITS = 24;
    localparam int MAX_VOICES  = 16;
    localparam int VOICE_BITS  = 5;

    typedef enum logic [2:0] {
        CFG_VOICE_COUNT = 3'd0,
        CFG_MOD_DEPTH   = 3'd1,
        CFG_LFO_INC     = 3'd2,
        CFG_SPREAD      = 3'd3,
        CFG_WET_MIX     = 3'd4
    } t_cfg_idx;

    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [33:0] SIN_A9  = 34'sd172272;
    localparam logic signed [33:0] SIN_COEF [0:3] = '{
        -34'sd5026996, 34'sd85569306, -34'sd693598669, 34'sd1686629713
    };

    // reciprocals for the lagrange divide by six or two, 24 fraction bits
    localparam logic [31:0] RECIP_SIXTH = 32'd2796203;
    localparam logic [31:0] RECIP_HALF  = 32'd8388608;

    // 2^32 / n as quotient and remainder, indexed by voice count
    localparam logic [31:0] LFO_STEP_Q [0:16] = '{
        32'd0, 32'd0, 32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
        32'd715827882, 32'd613566756, 32'd536870912, 32'd477218588, 32'd429496729,
        32'd390451572, 32'd357913941, 32'd330382099, 32'd306783378, 32'd286331153,
        32'd268435456
    };
    localparam logic [4:0] LFO_STEP_R [0:16] = '{
        5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd1, 5'd4, 5'd4, 5'd0, 5'd4, 5'd6,
        5'd4, 5'd4, 5'd9, 5'd4, 5'd1, 5'd0
    };

    // 65536 / d as quotient and remainder, indexed by voice count minus one
    localparam logic [16:0] PAN_STEP_Q [0:15] = '{
        17'd0, 17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922,
        17'd9362, 17'd8192, 17'd7281, 17'd6553, 17'd5957, 17'd5461, 17'd5041,
        17'd4681, 17'd4369
    };
    localparam logic [4:0] PAN_STEP_R [0:15] = '{
        5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd1, 5'd4, 5'd2, 5'd0, 5'd7, 5'd6,
        5'd9, 5'd4, 5'd3, 5'd2, 5'd1
    };

    // floor(sqrt(2^34 / n)), q16
    localparam logic [16:0] GAIN_TAB [0:16] = '{
        17'd0, 17'd0, 17'd92681, 17'd75674, 17'd65536, 17'd58617, 17'd53509,
        17'd49540, 17'd46340, 17'd43690, 17'd41448, 17'd39519, 17'd37837,
        17'd36352, 17'd35030, 17'd33842, 17'd32768
    };

endpackage
`default_nettype wire

[src/stereo_chorus_ensemble_core.sv]
// stereo chorus ensemble: delay line, shared multiplier and voice sequencer
// each input word runs the voice sequence once per active voice, then the gain and mix steps
// a new input word is taken only in the idle state, as every step uses the single shared 33 x 33 multiplier
// an output word may wait in its register while the next input word is taken
// reset: synchronous, active low; then a clearing pass zeroes all 4096 entries of the delay line
// input is held off during the clearing pass, configuration writes are taken throughout
`default_nettype none
module stereo_chorus_ensemble_core
    import sce_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [23:0] dry_sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [23:0] left_out, [47:24] right_out
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_PH, ST_SQ, ST_SQ2, ST_PM, ST_PA, ST_XM, ST_XA,
        ST_DM, ST_DA, ST_LS0, ST_LS1, ST_LS2, ST_LS3, ST_TS, ST_VAL, ST_PNM,
        ST_PNA, ST_VLM, ST_VRM, ST_VEND, ST_GLM, ST_GRM, ST_MLM, ST_MRM, ST_FIN
    } t_state;

    t_state r_state;

    logic [4:0]  r_vc;
    logic [19:0] r_depth;
    logic [31:0] r_inc;
    logic [15:0] r_spread;
    logic [15:0] r_mix;

    logic [ADDR_BITS-1:0] r_widx;
    logic [31:0]          r_phase;

    logic signed [23:0] r_dry;
    logic [3:0]         r_v;
    logic [31:0]        r_off;
    logic [4:0]         r_offrem;
    logic [16:0]        r_panq;
    logic [4:0]         r_panrem;
    logic [30:0]        r_x;
    logic               r_neg;
    logic [30:0]        r_x2;
    logic signed [33:0] r_acc;
    logic [1:0]         r_k;
    logic [30:0]        r_w;
    logic [ADDR_BITS-1:0] r_base;
    logic [15:0]        r_t;
    logic [2:0]         r_j;
    logic signed [23:0] r_p [0:3];
    logic [18:0]        r_l [0:3];
    logic signed [45:0] r_sum;
    logic signed [29:0] r_val;
    logic signed [17:0] r_pe;
    logic signed [47:0] r_accl;
    logic signed [47:0] r_accr;
    logic signed [29:0] r_wl;
    logic signed [29:0] r_wr;
    logic [23:0]        r_ol;
    logic signed [65:0] r_prod;
    logic               r_out_valid;
    logic [23:0]        r_out_l;
    logic [23:0]        r_out_r;

    logic [23:0] r_mem [0:DELAY_DEPTH-1];
    logic [23:0] r_rd;

    logic [4:0]  n;
    logic [3:0]  nm1;
    logic [15:0] spr_c;
    logic [15:0] mix_c;
    logic [16:0] m1;
    logic [17:0] m2;
    logic [17:0] m3;
    logic [1:0]  idx;
    logic        in_go;
    logic        fin_go;
    logic        mul_en;
    logic signed [32:0] ma;
    logic signed [32:0] mb;
    logic signed [65:0] mul_out;
    logic               mem_we;
    logic [23:0]        mem_wdata;
    logic [ADDR_BITS-1:0] rd_addr;

    logic [31:0] ph;
    logic [32:0] ph_d;
    logic [30:0] ph_x;
    logic        ph_neg;
    logic signed [33:0] mag;
    logic signed [33:0] sterm;
    logic signed [33:0] s_cl;
    logic [31:0] w_sum;
    logic [29:0] dly;
    logic [29:0] rpos;
    logic [4:0]  off_rs;
    logic [4:0]  pan_rs;
    logic signed [17:0] pan;
    logic signed [45:0] tap_term;

    function automatic logic signed [65:0] f_trunc(input logic signed [65:0] x,
                                                   input logic [5:0] k);
        logic signed [65:0] bias;
        bias = x[65] ? ((66'sd1 <<< k) - 66'sd1) : 66'sd0;
        return (x + bias) >>> k;
    endfunction

    function automatic logic [23:0] f_sat(input logic signed [65:0] v);
        logic [23:0] res;
        if (v > 66'sd8388607) begin
            res = 24'h7FFFFF;
        end else if (v < -66'sd8388608) begin
            res = 24'h800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    assign n      = (r_vc < 5'd2) ? 5'd2 : ((r_vc > 5'(MAX_VOICES)) ? 5'(MAX_VOICES) : r_vc);
    assign nm1    = 4'(n - 5'd1);
    assign spr_c  = (r_spread > 16'd32768) ? 16'd32768 : r_spread;
    assign mix_c  = (r_mix > 16'd32768) ? 16'd32768 : r_mix;
    assign m1     = 17'd65536 - 17'(r_t);
    assign m2     = 18'd131072 - 18'(r_t);
    assign m3     = 18'd196608 - 18'(r_t);
    assign idx    = r_j[1:0];
    assign in_go  = s_axis_tvalid && s_axis_tready;
    assign fin_go = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_r, r_out_l};

    // lfo phase folded onto a quarter wave
    always_comb begin
        ph   = r_phase + r_off;
        ph_d = ph[31] ? (33'h1_0000_0000 - 33'(ph)) : 33'(ph);
        if (ph_d <= 33'(ONE_Q30)) begin
            ph_x   = 31'(33'(ONE_Q30) - ph_d);
            ph_neg = 1'b0;
        end else begin
            ph_x   = 31'(ph_d - 33'(ONE_Q30));
            ph_neg = 1'b1;
        end
    end

    always_comb begin
        mag   = $signed({1'b0, r_prod[62:30]});
        sterm = r_acc[33] ? -mag : mag;
        if (sterm < 34'sd0) begin
            s_cl = 34'sd0;
        end else if (sterm > ONE_Q30) begin
            s_cl = ONE_Q30;
        end else begin
            s_cl = sterm;
        end
        w_sum = r_neg ? 32'(ONE_Q30 - s_cl) : 32'(ONE_Q30 + s_cl);
        dly   = 30'(r_prod[50:22]) + 30'(3 * 65536);
        if (dly > 30'((DELAY_DEPTH - 1) * 65536)) begin
            dly = 30'((DELAY_DEPTH - 1) * 65536);
        end
        rpos   = {14'(r_widx) + 14'(DELAY_DEPTH), 16'b0} - dly;
        off_rs = r_offrem + LFO_STEP_R[n];
        pan_rs = r_panrem + PAN_STEP_R[nm1];
        pan    = $signed({1'b0, r_panq}) - 18'sd32768;
        tap_term = 46'(r_prod);
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        ma     = 33'sd0;
        mb     = 33'sd0;
        unique case (r_state)
            ST_SQ: begin
                ma = $signed(33'(r_x));
                mb = $signed(33'(r_x));
            end
            ST_PM: begin
                ma = 33'(r_acc[33] ? -r_acc : r_acc);
                mb = $signed(33'(r_x2));
            end
            ST_XM: begin
                ma = 33'(r_acc[33] ? -r_acc : r_acc);
                mb = $signed(33'(r_x));
            end
            ST_DM: begin
                ma = $signed(33'(r_depth));
                mb = $signed(33'(r_w));
            end
            ST_LS0: begin
                ma = (idx == 2'd0) ? $signed(33'(m1)) : $signed(33'(r_t));
                mb = (idx == 2'd0 || idx == 2'd1) ? $signed(33'(m2)) : $signed(33'(m1));
            end
            ST_LS1: begin
                ma = $signed({1'b0, r_prod[47:16]});
                mb = (idx == 2'd3) ? $signed(33'(m2)) : $signed(33'(m3));
            end
            ST_LS2: begin
                ma = $signed({1'b0, r_prod[47:16]});
                mb = (idx == 2'd0 || idx == 2'd3) ? $signed(33'(RECIP_SIXTH))
                                                  : $signed(33'(RECIP_HALF));
            end
            ST_TS: begin
                ma = 33'(r_p[idx]);
                mb = $signed(33'(r_l[idx]));
            end
            ST_PNM: begin
                ma = 33'(pan);
                mb = $signed(33'(spr_c));
            end
            ST_VLM: begin
                ma = 33'(r_val);
                mb = 33'(18'sd32768 - r_pe);
            end
            ST_VRM: begin
                ma = 33'(r_val);
                mb = 33'(18'sd32768 + r_pe);
            end
            ST_GLM: begin
                ma = 33'(f_trunc(66'(r_accl), 6'd16));
                mb = $signed(33'(GAIN_TAB[n]));
            end
            ST_GRM: begin
                ma = 33'(f_trunc(66'(r_accr), 6'd16));
                mb = $signed(33'(GAIN_TAB[n]));
            end
            ST_MLM: begin
                ma = 33'(r_wl) - 33'(r_dry);
                mb = $signed(33'(mix_c));
            end
            ST_MRM: begin
                ma = 33'(r_wr) - 33'(r_dry);
                mb = $signed(33'(mix_c));
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_out = ma * mb;

    always_comb begin
        mem_we    = (r_state == ST_CLEAR) || in_go;
        mem_wdata = (r_state == ST_CLEAR) ? 24'd0 : s_axis_tdata;
        rd_addr   = r_base + ADDR_BITS'(idx);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_widx] <= mem_wdata;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_widx      <= '0;
            r_phase     <= '0;
            r_vc        <= 5'd2;
            r_depth     <= '0;
            r_inc       <= '0;
            r_spread    <= 16'd32768;
            r_mix       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_VOICE_COUNT: r_vc     <= i_cfg_data[4:0];
                    CFG_MOD_DEPTH:   r_depth  <= i_cfg_data[19:0];
                    CFG_LFO_INC:     r_inc    <= i_cfg_data;
                    CFG_SPREAD:      r_spread <= i_cfg_data[15:0];
                    CFG_WET_MIX:     r_mix    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_out_valid && m_axis_tready && !(r_state == ST_FIN && fin_go)) begin
                r_out_valid <= 1'b0;
            end
            if (mul_en) begin
                r_prod <= mul_out;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_widx <= r_widx + 1'b1;
                    if (r_widx == ADDR_BITS'(DELAY_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_go) begin
                        r_dry    <= $signed(s_axis_tdata);
                        r_v      <= '0;
                        r_off    <= '0;
                        r_offrem <= '0;
                        r_panq   <= '0;
                        r_panrem <= 5'(nm1 >> 1);
                        r_accl   <= '0;
                        r_accr   <= '0;
                        r_state  <= ST_PH;
                    end
                end
                ST_PH: begin
                    r_x     <= ph_x;
                    r_neg   <= ph_neg;
                    r_state <= ST_SQ;
                end
                ST_SQ: r_state <= ST_SQ2;
                ST_SQ2: begin
                    r_x2    <= r_prod[60:30];
                    r_acc   <= SIN_A9;
                    r_k     <= '0;
                    r_state <= ST_PM;
                end
                ST_PM: r_state <= ST_PA;
                ST_PA: begin
                    r_acc <= sterm + SIN_COEF[r_k];
                    r_k   <= r_k + 1'b1;
                    r_state <= (r_k == 2'd3) ? ST_XM : ST_PM;
                end
                ST_XM: r_state <= ST_XA;
                ST_XA: begin
                    r_w     <= w_sum[31:1];
                    r_state <= ST_DM;
                end
                ST_DM: r_state <= ST_DA;
                ST_DA: begin
                    r_base  <= rpos[27:16];
                    r_t     <= rpos[15:0];
                    r_j     <= '0;
                    r_sum   <= '0;
                    r_state <= ST_LS0;
                end
                ST_LS0: r_state <= ST_LS1;
                ST_LS1: begin
                    r_p[idx] <= $signed(r_rd);
                    r_state  <= ST_LS2;
                end
                ST_LS2: r_state <= ST_LS3;
                ST_LS3: begin
                    r_l[idx] <= r_prod[42:24];
                    if (idx == 2'd3) begin
                        r_j     <= '0;
                        r_state <= ST_TS;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_LS0;
                    end
                end
                ST_TS: begin
                    if (r_j != 3'd0) begin
                        r_sum <= (r_j == 3'd3) ? (r_sum - tap_term) : (r_sum + tap_term);
                    end
                    r_j     <= r_j + 1'b1;
                    r_state <= (r_j == 3'd4) ? ST_VAL : ST_TS;
                end
                ST_VAL: begin
                    r_val   <= 30'(f_trunc(66'(r_sum), 6'd16));
                    r_state <= ST_PNM;
                end
                ST_PNM: r_state <= ST_PNA;
                ST_PNA: begin
                    r_pe    <= 18'(f_trunc(r_prod, 6'd15));
                    r_state <= ST_VLM;
                end
                ST_VLM: r_state <= ST_VRM;
                ST_VRM: begin
                    r_accl  <= r_accl + 48'(r_prod);
                    r_state <= ST_VEND;
                end
                ST_VEND: begin
                    r_accr <= r_accr + 48'(r_prod);
                    r_v    <= r_v + 1'b1;
                    if (off_rs >= n) begin
                        r_off    <= r_off + LFO_STEP_Q[n] + 32'd1;
                        r_offrem <= off_rs - n;
                    end else begin
                        r_off    <= r_off + LFO_STEP_Q[n];
                        r_offrem <= off_rs;
                    end
                    if (pan_rs >= 5'(nm1)) begin
                        r_panq   <= r_panq + PAN_STEP_Q[nm1] + 17'd1;
                        r_panrem <= pan_rs - 5'(nm1);
                    end else begin
                        r_panq   <= r_panq + PAN_STEP_Q[nm1];
                        r_panrem <= pan_rs;
                    end
                    r_state <= (r_v == nm1) ? ST_GLM : ST_PH;
                end
                ST_GLM: r_state <= ST_GRM;
                ST_GRM: begin
                    r_wl    <= 30'(f_trunc(r_prod, 6'd16));
                    r_state <= ST_MLM;
                end
                ST_MLM: begin
                    r_wr    <= 30'(f_trunc(r_prod, 6'd16));
                    r_state <= ST_MRM;
                end
                ST_MRM: begin
                    r_ol    <= f_sat(66'(r_dry) + f_trunc(r_prod, 6'd15));
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (fin_go) begin
                        r_out_l     <= r_ol;
                        r_out_r     <= f_sat(66'(r_dry) + f_trunc(r_prod, 6'd15));
                        r_out_valid <= 1'b1;
                        r_widx      <= r_widx + 1'b1;
                        r_phase     <= r_phase + r_inc;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_go |=> r_state == ST_PH)
        else $error("accepted word did not start the voice sequence");

    a_write_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && fin_go) |=>
            (r_widx == $past(r_widx) + 1'b1) && m_axis_tvalid && r_state == ST_IDLE)
        else $error("finished word did not advance the write pointer");

    a_voice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR && r_state != ST_IDLE && r_state != ST_GLM
            && r_state != ST_GRM && r_state != ST_MLM && r_state != ST_MRM
            && r_state != ST_FIN) |-> (5'(r_v) < n))
        else $error("voice counter beyond active voices");

    a_offset_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR && r_state != ST_IDLE) |-> (r_offrem < n))
        else $error("phase offset remainder out of range");

endmodule
`default_nettype wire

[verif/tb_stereo_chorus_ensemble_core.sv]
// testbench for the stereo chorus ensemble core: directed and random words checked against a predictor
`default_nettype none
module tb_stereo_chorus_ensemble_core;
    import sce_pkg::*;

    typedef struct packed {
        logic [23:0] right_out;
        logic [23:0] left_out;
    } t_stereo;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    stereo_chorus_ensemble_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    localparam int LIMIT = 20000;

    // predictor state
    logic signed [23:0] line_mem [0:DELAY_DEPTH-1];
    logic [11:0] wr_ptr;
    logic [31:0] phase_acc;
    logic [4:0]  p_voices;
    logic [19:0] p_depth;
    logic [31:0] p_inc;
    logic [15:0] p_spread;
    logic [15:0] p_mix;

    t_stereo expected_q [$];
    int errors;
    int idle_cycles;
    bit hold_off;
    bit timed_out;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint mul30(longint a, longint b);
        longint m;
        longint r;
        m = a < 0 ? -a : a;
        r = (m * b) >>> 30;
        return a < 0 ? -r : r;
    endfunction

    function automatic longint quarter_sine(longint x);
        longint x2;
        longint acc;
        x2 = (x * x) >>> 30;
        acc = 172272;
        acc = mul30(acc, x2) - 5026996;
        acc = mul30(acc, x2) + 85569306;
        acc = mul30(acc, x2) - 693598669;
        acc = mul30(acc, x2) + 1686629713;
        acc = mul30(acc, x);
        if (acc < 0) acc = 0;
        if (acc > 64'sd1073741824) acc = 64'sd1073741824;
        return acc;
    endfunction

    function automatic longint raised_cos(logic [31:0] p);
        longint d;
        longint q;
        q = 64'sd1073741824;
        d = p < 32'h8000_0000 ? longint'(p) : 64'sh1_0000_0000 - longint'(p);
        if (d <= q) return (q + quarter_sine(q - d)) >>> 1;
        return (q - quarter_sine(d - q)) >>> 1;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r;
        longint b;
        r = 0;
        for (b = 64'd1 << 20; b != 0; b = b >>> 1)
            if ((r + b) * (r + b) <= n) r += b;
        return r;
    endfunction

    function automatic logic [23:0] clip24(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    function automatic t_stereo chorus_predict(logic [23:0] dry_bits);
        longint dry, n, spr, mix, gain, acc_l, acc_r, v;
        longint dly, rpos, base, t, m1, m2, m3, l0, l1, l2, l3;
        longint p0, p1, p2, p3, sum, val, pan, pe, wl, wr;
        logic [31:0] ph;
        t_stereo res;
        dry = longint'($signed(dry_bits));
        n = p_voices < 2 ? 2 : (p_voices > MAX_VOICES ? MAX_VOICES : p_voices);
        spr = p_spread > 32768 ? 32768 : p_spread;
        mix = p_mix > 32768 ? 32768 : p_mix;
        gain = int_sqrt((64'd1 << 34) / n);
        acc_l = 0;
        acc_r = 0;
        line_mem[wr_ptr] = dry_bits;
        for (v = 0; v < n; v++) begin
            ph = phase_acc + 32'((v << 32) / n);
            dly = (64'd3 << 16) + ((longint'(p_depth) * raised_cos(ph)) >>> 22);
            if (dly > (longint'(DELAY_DEPTH - 1) << 16)) dly = longint'(DELAY_DEPTH - 1) << 16;
            rpos = ((longint'(wr_ptr) + DELAY_DEPTH) << 16) - dly;
            base = (rpos >>> 16) % DELAY_DEPTH;
            t = rpos & 16'hFFFF;
            p0 = line_mem[base];
            p1 = line_mem[(base + 1) % DELAY_DEPTH];
            p2 = line_mem[(base + 2) % DELAY_DEPTH];
            p3 = line_mem[(base + 3) % DELAY_DEPTH];
            m1 = 65536 - t;
            m2 = 131072 - t;
            m3 = 196608 - t;
            l0 = ((((m1 * m2) >>> 16) * m3) >>> 16) / 6;
            l1 = ((((t * m2) >>> 16) * m3) >>> 16) / 2;
            l2 = ((((t * m1) >>> 16) * m3) >>> 16) / 2;
            l3 = ((((t * m1) >>> 16) * m2) >>> 16) / 6;
            sum = p0 * l0 + p1 * l1 - p2 * l2 + p3 * l3;
            val = sum / 65536;
            pan = (65536 * v + (n - 1) / 2) / (n - 1) - 32768;
            pe = pan * spr / 32768;
            acc_l += val * (32768 - pe);
            acc_r += val * (32768 + pe);
        end
        wl = (acc_l / 65536) * gain / 65536;
        wr = (acc_r / 65536) * gain / 65536;
        res.left_out = clip24(dry + (wl - dry) * mix / 32768);
        res.right_out = clip24(dry + (wr - dry) * mix / 32768);
        wr_ptr = wr_ptr + 1'b1;
        phase_acc = phase_acc + p_inc;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
        errors++;
    endtask

    // output checker and receiver stall pattern
    always @(posedge i_clk) begin
        t_stereo want;
        t_stereo got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_q.size() == 0) begin
                $display("unexpected output word %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.left_out !== want.left_out)
                    report_mismatch("left_out", got.left_out, want.left_out);
                if (got.right_out !== want.right_out)
                    report_mismatch("right_out", got.right_out, want.right_out);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off) m_axis_tready <= 1'b0;
        else if (($time / 800) % 3 == 0) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_sample(logic [23:0] s);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = s;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_q.push_back(chorus_predict(s));
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_burst(int count);
        int k;
        int gap;
        k = 0;
        while (k < count) begin
            send_sample(24'($urandom()));
            k++;
            if ($urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 200);
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (800) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_VOICE_COUNT: p_voices = val[4:0];
            CFG_MOD_DEPTH:   p_depth  = val[19:0];
            CFG_LFO_INC:     p_inc    = val;
            CFG_SPREAD:      p_spread = val[15:0];
            CFG_WET_MIX:     p_mix    = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_all(int nv, int depth, logic [31:0] inc, int spr, int mix);
        write_reg(CFG_VOICE_COUNT, nv);
        write_reg(CFG_MOD_DEPTH, depth);
        write_reg(CFG_LFO_INC, inc);
        write_reg(CFG_SPREAD, spr);
        write_reg(CFG_WET_MIX, mix);
    endtask

    task automatic test_dry_extremes();
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h000000);
        send_sample(24'hFFFFFF);
        send_sample(24'h555555);
        send_sample(24'hAAAAAA);
        drain();
    endtask

    task automatic test_wet_corners();
        int k;
        set_all(16, 20'hFFC00, 32'hFFFF_FFFF, 32768, 32768);
        for (k = 0; k < 6; k++) send_sample(k[0] ? 24'h7FFFFF : 24'h800000);
        drain();
        set_all(0, 20'hFFFFF, 32'h0100_0000, 16'hFFFF, 16'hFFFF);
        for (k = 0; k < 5; k++) send_sample(24'($urandom()));
        drain();
        set_all(31, 1000, 32'h8000_0000, 0, 16384);
        for (k = 0; k < 5; k++) send_sample(24'($urandom()));
        drain();
    endtask

    task automatic test_random_phases();
        int ph;
        for (ph = 0; ph < 8; ph++) begin
            set_all($urandom_range(0, 31), $urandom_range(0, 20'hFFFFF), $urandom(),
                    $urandom_range(0, 40000), $urandom_range(0, 40000));
            send_burst(100);
            drain();
        end
    endtask

    task automatic test_backpressure();
        int k;
        set_all(2, 512, 32'h0123_4567, 20000, 30000);
        hold_off = 1'b1;
        fork
            begin
                repeat (2000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (k = 0; k < 20; k++) send_sample(24'($urandom()));
        join
        drain();
    endtask

    initial begin
        errors = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_VOICE_COUNT;
        i_cfg_data = '0;
        for (int k = 0; k < DELAY_DEPTH; k++) line_mem[k] = '0;
        wr_ptr = '0;
        phase_acc = '0;
        p_voices = 2;
        p_depth = 0;
        p_inc = 0;
        p_spread = 32768;
        p_mix = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_dry_extremes();
        test_wet_corners();
        test_backpressure();
        test_random_phases();
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
